// ===== hdl/ophc_pkg.sv =====
// shared types and constants for the reflow oven heater controller
// no dependencies; imported by every module of the block
package ophc_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_REFLOW = 3'd1,
        MODE_ALARM  = 3'd2,
        MODE_COOL   = 3'd3,
        MODE_ERROR  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // configuration register indexes
    localparam logic [2:0] CFG_HEATER_GAIN   = 3'd0;
    localparam logic [2:0] CFG_PERIOD_COUNTS = 3'd1;
    localparam logic [2:0] CFG_COOL_THRESH   = 3'd2;
    localparam logic [2:0] CFG_OVER_TEMP     = 3'd3;
    localparam logic [2:0] CFG_ALARM_LEAD    = 3'd4;

    localparam logic [3:0] GAIN_RESET      = 4'd4;
    localparam logic [6:0] PERIOD_RESET    = 7'd64;
    localparam logic [9:0] COOL_RESET      = 10'd50;
    localparam logic [9:0] OVER_TEMP_RESET = 10'd300;
    localparam logic [7:0] ALARM_RESET     = 8'd2;
    localparam logic [6:0] CYCLE_RESET     = 7'd64;
    localparam logic [6:0] ON_TIME_RESET   = 7'd64;

    typedef struct packed {
        logic [3:0] heater_gain;
        logic [6:0] period_counts;
        logic [9:0] cool_threshold;
        logic [9:0] over_temp_limit;
        logic [7:0] alarm_lead_seconds;
    } t_cfg;

    // next duty state from one heater step
    typedef struct packed {
        logic       heater;
        logic [6:0] cycle_count;
        logic [6:0] on_time;
    } t_heat;

endpackage

// ===== hdl/oven_profile_heater_controller.sv =====
// top level of the reflow oven heater controller: input register, mode logic, result register
// depends on ophc_pkg, ophc_cfg_regs and ophc_heater
//
// One item a cycle while the output keeps up: each item is registered on entry, the mode and
// duty counters update from that registered item when the result register can advance, and
// its result is held in that output register, which drives m_axis_tvalid. The only recurrence
// is the controller state, so an item can be accepted every cycle while the output side
// keeps up; a stalled output holds one result and one registered item before s_axis_tready
// drops. The configuration port is always ready.
module oven_profile_heater_controller
    import ophc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [9:0] temp_reading, [17:10] target_temp, [18] second_tick, [34:19] profile_duration
    input  logic [39:0] s_axis_tdata,
    // [1:0] action
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] heater_on, [3:1] oven_mode, [19:4] seconds_into, [35:20] seconds_left,
    // [36] start_accepted
    output logic [39:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);

    t_cfg cfg;

    ophc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign o_cfg_ready = 1'b1;

    // input register
    logic        r_in_valid;
    t_action     r_action;
    logic [9:0]  r_temp;
    logic [7:0]  r_target;
    logic        r_sec;
    logic [15:0] r_duration;

    // controller state
    t_mode       r_mode;
    logic [15:0] r_elapsed;
    logic [15:0] r_remaining;
    logic [6:0]  r_cycle;
    logic [6:0]  r_on_time;
    logic        r_heater;

    // result register
    logic        r_out_valid;
    logic        r_accepted;

    t_mode       n_mode;
    logic [15:0] n_elapsed;
    logic [15:0] n_remaining;
    logic [6:0]  n_cycle;
    logic [6:0]  n_on_time;
    logic        n_heater;
    logic        n_accepted;

    logic  advance;
    logic  process;
    logic  in_fire;
    t_mode mode_pre;
    t_heat heat_next;

    assign advance       = !r_out_valid || m_axis_tready;
    assign process       = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    ophc_heater u_heater (
        .i_gain          (cfg.heater_gain),
        .i_period_counts (cfg.period_counts),
        .i_temp8         (r_temp[7:0]),
        .i_target        (r_target),
        .i_cycle_count   (r_cycle),
        .i_on_time       (r_on_time),
        .o_next          (heat_next)
    );

    always_comb begin
        n_mode      = r_mode;
        n_elapsed   = r_elapsed;
        n_remaining = r_remaining;
        n_cycle     = r_cycle;
        n_on_time   = r_on_time;
        n_heater    = r_heater;
        n_accepted  = 1'b0;
        // on a tick, a hot idle oven goes to cooldown unless the over-temperature check sends it to error
        mode_pre    = (r_temp > cfg.cool_threshold && r_mode == MODE_IDLE) ? MODE_COOL
                                                                           : r_mode;
        case (r_action)
            ACT_TICK: begin
                if (r_temp > cfg.over_temp_limit) begin
                    n_mode   = MODE_ERROR;
                    n_heater = 1'b0;
                end else if (mode_pre == MODE_REFLOW || mode_pre == MODE_ALARM) begin
                    if (r_sec) begin
                        n_elapsed = r_elapsed + 16'd1;
                        if (r_remaining != 16'd0) begin
                            n_remaining = r_remaining - 16'd1;
                        end
                    end
                    n_cycle   = heat_next.cycle_count;
                    n_on_time = heat_next.on_time;
                    n_heater  = heat_next.heater;
                    if (n_remaining == 16'd0) begin
                        n_mode   = MODE_COOL;
                        n_heater = 1'b0;
                    end else if (n_remaining <= {8'd0, cfg.alarm_lead_seconds}) begin
                        n_mode = MODE_ALARM;
                    end else begin
                        n_mode = mode_pre;
                    end
                end else if (mode_pre == MODE_COOL && r_temp < cfg.cool_threshold) begin
                    n_mode = MODE_IDLE;
                end else begin
                    n_mode = mode_pre;
                end
            end
            ACT_START: begin
                if (r_mode == MODE_IDLE) begin
                    n_mode      = MODE_REFLOW;
                    n_elapsed   = 16'd0;
                    n_remaining = r_duration;
                    n_accepted  = 1'b1;
                end
            end
            ACT_STOP: begin
                n_mode   = MODE_COOL;
                n_heater = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_IDLE;
            r_elapsed   <= 16'd0;
            r_remaining <= 16'd0;
            r_cycle     <= CYCLE_RESET;
            r_on_time   <= ON_TIME_RESET;
            r_heater    <= 1'b0;
            r_accepted  <= 1'b0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (process) begin
                r_in_valid <= 1'b0;
            end
            if (process) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_elapsed   <= n_elapsed;
                r_remaining <= n_remaining;
                r_cycle     <= n_cycle;
                r_on_time   <= n_on_time;
                r_heater    <= n_heater;
                r_accepted  <= n_accepted;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_action   <= t_action'(s_axis_tuser);
            r_temp     <= s_axis_tdata[9:0];
            r_target   <= s_axis_tdata[17:10];
            r_sec      <= s_axis_tdata[18];
            r_duration <= s_axis_tdata[34:19];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_accepted, r_remaining, r_elapsed, r_mode, r_heater};

    // heater only drives while a profile runs
    a_heater_mode : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_heater |-> (r_mode == MODE_REFLOW || r_mode == MODE_ALARM))
        else $error("heater on outside reflow or alarm");

    // an accepted start always reports a fresh profile
    a_start_fresh : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_accepted) |-> (r_mode == MODE_REFLOW && r_elapsed == 16'd0))
        else $error("accepted start without fresh reflow state");

    // a registered item is held while the result register is stalled
    a_item_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready) |=> r_in_valid)
        else $error("registered item dropped under output stall");

endmodule

// ===== hdl/ophc_cfg_regs.sv =====
// configuration register file for the reflow oven heater controller
// depends on ophc_pkg
module ophc_cfg_regs
    import ophc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_wr_en,
    input  logic [2:0] i_wr_index,
    input  logic [9:0] i_wr_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.heater_gain        <= GAIN_RESET;
            r_cfg.period_counts      <= PERIOD_RESET;
            r_cfg.cool_threshold     <= COOL_RESET;
            r_cfg.over_temp_limit    <= OVER_TEMP_RESET;
            r_cfg.alarm_lead_seconds <= ALARM_RESET;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_HEATER_GAIN:   r_cfg.heater_gain        <= i_wr_data[3:0];
                CFG_PERIOD_COUNTS: r_cfg.period_counts      <= i_wr_data[6:0];
                CFG_COOL_THRESH:   r_cfg.cool_threshold     <= i_wr_data;
                CFG_OVER_TEMP:     r_cfg.over_temp_limit    <= i_wr_data;
                CFG_ALARM_LEAD:    r_cfg.alarm_lead_seconds <= i_wr_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/ophc_heater.sv =====
// time-proportional heater step: clamped error, duty counter reload, heater drive
// depends on ophc_pkg
module ophc_heater
    import ophc_pkg::*;
(
    input  logic [3:0] i_gain,
    input  logic [6:0] i_period_counts,
    input  logic [7:0] i_temp8,
    input  logic [7:0] i_target,
    input  logic [6:0] i_cycle_count,
    input  logic [6:0] i_on_time,
    output t_heat      o_next
);

    logic [6:0]         period;
    logic signed [8:0]  diff;
    logic signed [13:0] prod;
    logic [6:0]         err;
    logic               on_now;
    logic [6:0]         on_dec;

    always_comb begin
        // zero period acts as one
        period = (i_period_counts == 7'd0) ? 7'd1 : i_period_counts;
        diff   = $signed({1'b0, i_target}) - $signed({1'b0, i_temp8});
        prod   = $signed({1'b0, i_gain}) * diff;
        if (prod < 14'sd0) begin
            err = 7'd0;
        end else if (prod > $signed({7'd0, period})) begin
            err = period;
        end else begin
            err = prod[6:0];
        end

        on_now = (i_on_time > 7'd1);
        on_dec = on_now ? (i_on_time - 7'd1) : i_on_time;

        o_next.heater      = on_now;
        o_next.on_time     = (i_cycle_count == 7'd0) ? err : on_dec;
        o_next.cycle_count = ((i_cycle_count == 7'd0) ? period : i_cycle_count) - 7'd1;
    end

endmodule

// ===== bench/tb_oven_profile_heater_controller.sv =====
// self-checking bench for oven_profile_heater_controller: directed items, then random
// profile runs under six register settings, every result checked against a local predictor
// depends on ophc_pkg and the controller RTL
module tb_oven_profile_heater_controller;
    timeunit 1ns;
    timeprecision 1ps;
    import ophc_pkg::*;

    typedef struct {
        logic        heater_on;
        t_mode       mode;
        logic [15:0] into;
        logic [15:0] left;
        logic        accepted;
    } oven_report_t;

    // predicts the controller's state item by item and holds the reports still to come
    class heater_scoreboard;
        logic [3:0]   gain;
        logic [6:0]   period;
        logic [9:0]   cool_thr;
        logic [9:0]   over_lim;
        logic [7:0]   lead;
        t_mode        mode;
        logic [15:0]  elapsed;
        logic [15:0]  remaining;
        logic [6:0]   cycle_cnt;
        logic [6:0]   on_cnt;
        logic         heater;
        oven_report_t expected_reports[$];
        int           mismatches;
        int           results_seen;
        int           starts_taken;
        int           alarm_reports;
        int           error_reports;

        function new();
            gain = GAIN_RESET;
            period = PERIOD_RESET;
            cool_thr = COOL_RESET;
            over_lim = OVER_TEMP_RESET;
            lead = ALARM_RESET;
            mode = MODE_IDLE;
            elapsed = '0;
            remaining = '0;
            cycle_cnt = CYCLE_RESET;
            on_cnt = ON_TIME_RESET;
            heater = 1'b0;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10) $display("mismatch at %0t:%s", $realtime, what);
        endfunction

        function void write_reg(logic [2:0] idx, logic [9:0] data);
            case (idx)
                CFG_HEATER_GAIN:   gain = data[3:0];
                CFG_PERIOD_COUNTS: period = data[6:0];
                CFG_COOL_THRESH:   cool_thr = data;
                CFG_OVER_TEMP:     over_lim = data;
                CFG_ALARM_LEAD:    lead = data[7:0];
                default: ;
            endcase
        endfunction

        // time-proportional drive: on-time reloads from the clamped error once per period
        function void duty_step(logic [7:0] temp8, logic [7:0] target);
            int span;
            int drive;
            span = (period == 0) ? 1 : int'(period);
            drive = int'(gain) * (int'(target) - int'(temp8));
            if (drive < 0) drive = 0;
            if (drive > span) drive = span;
            if (on_cnt > 7'd1) begin
                heater = 1'b1;
                on_cnt = on_cnt - 7'd1;
            end else begin
                heater = 1'b0;
            end
            if (cycle_cnt == 0) begin
                cycle_cnt = span[6:0];
                on_cnt = drive[6:0];
            end
            cycle_cnt = cycle_cnt - 7'd1;
        endfunction

        function void control_tick(logic [9:0] temp, logic [7:0] target, logic sec);
            if (temp > cool_thr && mode == MODE_IDLE) mode = MODE_COOL;
            if (temp > over_lim) begin
                mode = MODE_ERROR;
                heater = 1'b0;
            end else if (mode == MODE_ALARM || mode == MODE_REFLOW) begin
                if (sec) begin
                    elapsed = elapsed + 16'd1;
                    if (remaining != 0) remaining = remaining - 16'd1;
                end
                duty_step(temp[7:0], target);
                if (remaining == 0) begin
                    mode = MODE_COOL;
                    heater = 1'b0;
                end else if (remaining <= lead) begin
                    mode = MODE_ALARM;
                end
            end else if (mode == MODE_COOL && temp < cool_thr) begin
                mode = MODE_IDLE;
            end
        endfunction

        function void note_item(t_action act, logic [39:0] data);
            oven_report_t rep;
            logic taken;
            taken = 1'b0;
            case (act)
                ACT_TICK: control_tick(data[9:0], data[17:10], data[18]);
                ACT_START: begin
                    if (mode == MODE_IDLE) begin
                        mode = MODE_REFLOW;
                        elapsed = '0;
                        remaining = data[34:19];
                        taken = 1'b1;
                    end
                end
                ACT_STOP: begin
                    mode = MODE_COOL;
                    heater = 1'b0;
                end
                default: ;
            endcase
            rep.heater_on = heater;
            rep.mode = mode;
            rep.into = elapsed;
            rep.left = remaining;
            rep.accepted = taken;
            expected_reports.push_back(rep);
        endfunction

        function void check_result(logic [39:0] data);
            oven_report_t want;
            string diffs;
            results_seen++;
            if (data[3:1] == MODE_ALARM) alarm_reports++;
            if (data[3:1] == MODE_ERROR) error_reports++;
            if (data[36] === 1'b1) starts_taken++;
            if (expected_reports.size() == 0) begin
                flag($sformatf(" result %h arrived with nothing expected", data));
                return;
            end
            want = expected_reports.pop_front();
            diffs = "";
            if (data[0] !== want.heater_on)
                diffs = {diffs, $sformatf(" heater_on exp %0d got %0d", want.heater_on, data[0])};
            if (data[3:1] !== want.mode)
                diffs = {diffs, $sformatf(" mode exp %0d got %0d", want.mode, data[3:1])};
            if (data[19:4] !== want.into)
                diffs = {diffs, $sformatf(" seconds_into exp %0d got %0d", want.into, data[19:4])};
            if (data[35:20] !== want.left)
                diffs = {diffs, $sformatf(" seconds_left exp %0d got %0d", want.left, data[35:20])};
            if (data[36] !== want.accepted)
                diffs = {diffs, $sformatf(" start_accepted exp %0d got %0d",
                                          want.accepted, data[36])};
            if (diffs != "") flag(diffs);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = ACT_TICK;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [9:0]  i_cfg_data = '0;

    heater_scoreboard board = new();
    bit burst_mode = 1'b0;
    int items_sent = 0;
    int settings_run = 0;
    int profiles_run = 0;

    oven_profile_heater_controller DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= burst_mode || ($urandom_range(0, 99) >= 9);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) board.write_reg(i_cfg_index, i_cfg_data);
            if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                board.note_item(t_action'(s_axis_tuser), s_axis_tdata);
        end
    end

    task automatic send_item(t_action act, logic [9:0] temp, logic [7:0] target, logic sec,
                             logic [15:0] dur);
        while (!burst_mode && $urandom_range(0, 99) < 9) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {5'd0, dur, sec, target, temp};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // hold off the sender until every report is in, then let the pipeline empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // leaves valid high so that back-to-back writes need no extra step
    task automatic write_reg(logic [2:0] idx, logic [9:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic apply_settings(int gain, int period, int cool, int over, int lead);
        write_reg(CFG_HEATER_GAIN, 10'(gain));
        write_reg(CFG_PERIOD_COUNTS, 10'(period));
        write_reg(CFG_COOL_THRESH, 10'(cool));
        write_reg(CFG_OVER_TEMP, 10'(over));
        write_reg(CFG_ALARM_LEAD, 10'(lead));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [9:0] safe_temp();
        return 10'($urandom_range(0, board.over_lim));
    endfunction

    function automatic logic [9:0] cool_temp();
        int top;
        top = int'(board.cool_thr) - 1;
        if (top > int'(board.over_lim)) top = board.over_lim;
        return (top < 0) ? 10'd0 : 10'($urandom_range(0, top));
    endfunction

    function automatic logic [7:0] pick_target(logic [9:0] temp);
        int near;
        if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
        near = int'(temp[7:0]) + $urandom_range(0, 40) - 8;
        if (near < 0) near = 0;
        if (near > 255) near = 255;
        return near[7:0];
    endfunction

    function automatic logic [15:0] pick_duration();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7) return 16'($urandom_range(0, 40));
        if (roll < 9) return 16'($urandom_range(41, 300));
        return 16'($urandom_range(0, 65535));
    endfunction

    // one well-formed run: cool down to idle, start, then ticks with some noise mixed in
    task automatic run_profile();
        int steps;
        int roll;
        logic [9:0] temp;
        temp = cool_temp();
        send_item(ACT_TICK, temp, pick_target(temp), 1'($urandom_range(0, 1)), 16'($urandom));
        if ($urandom_range(0, 99) < 15 && board.cool_thr < board.over_lim) begin
            // hot oven while idle goes to cooldown first
            temp = 10'($urandom_range(board.cool_thr + 1, board.over_lim));
            send_item(ACT_TICK, temp, pick_target(temp), 1'b0, 16'($urandom));
            temp = cool_temp();
            send_item(ACT_TICK, temp, pick_target(temp), 1'b1, 16'($urandom));
        end
        send_item(ACT_START, 10'($urandom), 8'($urandom), 1'($urandom_range(0, 1)),
                  pick_duration());
        steps = $urandom_range(4, 40);
        repeat (steps) begin
            roll = $urandom_range(0, 99);
            temp = safe_temp();
            if (roll < 4 && board.over_lim < 10'd1023) begin
                temp = 10'($urandom_range(board.over_lim + 1, 1023));
                send_item(ACT_TICK, temp, pick_target(temp), 1'($urandom_range(0, 1)),
                          16'($urandom));
            end else if (roll < 7) begin
                send_item(ACT_STOP, 10'($urandom), 8'($urandom), 1'($urandom_range(0, 1)),
                          16'($urandom));
            end else if (roll < 9) begin
                send_item(ACT_START, 10'($urandom), 8'($urandom), 1'($urandom_range(0, 1)),
                          pick_duration());
            end else if (roll < 11) begin
                send_item(ACT_NONE, 10'($urandom), 8'($urandom), 1'($urandom_range(0, 1)),
                          16'($urandom));
            end else begin
                send_item(ACT_TICK, temp, pick_target(temp), $urandom_range(0, 1) &&
                          $urandom_range(0, 1) | $urandom_range(0, 1), 16'($urandom));
            end
        end
        profiles_run++;
        if (profiles_run % 8 == 7) settle();
    endtask

    task automatic run_random(int count);
        int goal;
        goal = items_sent + count;
        while (items_sent < goal) run_profile();
        settle();
        settings_run++;
    endtask

    initial begin
        #4ms;
        $display("timeout at %0t", $realtime);
        $display("tb_oven_profile_heater_controller failed");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part under reset settings
        send_item(ACT_TICK, 10'd0, 8'd0, 1'b0, 16'd0);
        send_item(ACT_NONE, 10'h3FF, 8'hFF, 1'b1, 16'hFFFF);
        send_item(ACT_STOP, 10'd0, 8'd0, 1'b0, 16'd0);
        send_item(ACT_TICK, 10'd10, 8'd0, 1'b0, 16'd0);
        send_item(ACT_START, 10'd0, 8'd0, 1'b0, 16'd0);
        send_item(ACT_START, 10'd0, 8'd0, 1'b0, 16'd9);
        send_item(ACT_TICK, 10'd20, 8'd255, 1'b0, 16'd0);
        send_item(ACT_TICK, 10'd0, 8'd0, 1'b0, 16'd0);
        send_item(ACT_START, 10'd0, 8'd0, 1'b0, 16'hFFFF);
        send_item(ACT_TICK, 10'd255, 8'd0, 1'b1, 16'd0);
        send_item(ACT_TICK, 10'd256, 8'd255, 1'b1, 16'd0);
        send_item(ACT_TICK, 10'd1023, 8'd128, 1'b1, 16'd0);
        send_item(ACT_TICK, 10'd0, 8'd0, 1'b1, 16'd0);
        send_item(ACT_START, 10'd0, 8'd0, 1'b0, 16'd5);
        send_item(ACT_STOP, 10'd0, 8'd0, 1'b0, 16'd0);
        send_item(ACT_TICK, 10'd100, 8'd0, 1'b0, 16'd0);
        send_item(ACT_TICK, 10'd0, 8'd0, 1'b0, 16'd0);
        send_item(ACT_TICK, 10'd200, 8'd0, 1'b0, 16'd0);
        send_item(ACT_TICK, 10'd49, 8'd0, 1'b0, 16'd0);
        send_item(ACT_START, 10'd0, 8'd0, 1'b0, 16'd4);
        repeat (4) send_item(ACT_TICK, 10'd30, 8'd90, 1'b1, 16'd0);
        settle();

        run_random(220);

        apply_settings(15, 1, 100, 1023, 0);
        run_random(220);

        burst_mode = 1'b1;
        apply_settings(0, 127, 1023, 1023, 255);
        run_random(220);
        burst_mode = 1'b0;

        // zero period acts as one
        apply_settings(1, 0, 30, 700, 10);
        run_random(220);

        apply_settings(15, 127, 0, 0, 0);
        run_random(80);

        // upper data bits beyond each register's width are dropped, unused indexes ignored
        write_reg(CFG_HEATER_GAIN, 10'h3F9);
        write_reg(CFG_PERIOD_COUNTS, 10'h394);
        write_reg(CFG_COOL_THRESH, 10'd200);
        write_reg(CFG_OVER_TEMP, 10'd250);
        write_reg(CFG_ALARM_LEAD, 10'h3C8);
        write_reg(3'd5, 10'h3FF);
        write_reg(3'd6, 10'h155);
        write_reg(3'd7, 10'h2AA);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        run_random(220);

        if (board.pending() != 0)
            board.flag($sformatf(" %0d results never arrived", board.pending()));
        $display("run covered %0d items in %0d profiles over %0d register settings",
                 items_sent, profiles_run, settings_run);
        $display("%0d results checked: %0d starts accepted, %0d in alarm, %0d in error, %0d bad",
                 board.results_seen, board.starts_taken, board.alarm_reports,
                 board.error_reports, board.mismatches);
        if (board.mismatches == 0) begin
            $display("tb_oven_profile_heater_controller passed");
        end else begin
            $display("tb_oven_profile_heater_controller failed");
        end
        $finish;
    end

endmodule
